### sv/psl_pkg.sv
// Pedal sensor linearizer package: widths, sensor coefficients, code limits.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none
package psl_pkg;

   localparam int ADC_W   = 12;
   localparam int Q_BITS  = 16;
   localparam int CODE_W  = 8;
   localparam int OFF_W   = 8;
   localparam int RAD_W   = 50;   // radicand, always below 2^49
   localparam int NUM_W   = 48;   // signed Q16 datapath
   localparam int DEN_W   = 26;   // divisor k * (a - x)
   localparam int P_W     = 25;
   localparam int ROOT_W  = (RAD_W + 2 * Q_BITS) / 2;
   localparam int ADC_FULL = 4096;

   localparam logic       REQ_CONVERT = 1'b0;
   localparam logic       REQ_CALIB   = 1'b1;

   localparam logic [1:0] SEL_BRAKE = 2'd0;
   localparam logic [1:0] SEL_ACC1  = 2'd1;
   localparam logic [1:0] SEL_ACC2  = 2'd2;
   localparam logic [1:0] SEL_NONE  = 2'd3;

   localparam logic [OFF_W-1:0]  OFF_RESET = 8'd2;

   localparam logic [CODE_W-1:0] CODE_LOW  = 8'd0;
   localparam logic [CODE_W-1:0] CODE_MIN  = 8'd1;
   localparam logic [CODE_W-1:0] CODE_MAX  = 8'd254;
   localparam logic [CODE_W-1:0] CODE_HIGH = 8'd255;

   localparam int TOL  = 10;
   localparam int SPAN = 254;

   localparam logic signed [NUM_W-1:0] VAL_SPAN = NUM_W'(SPAN * (1 << Q_BITS));
   localparam logic signed [NUM_W-1:0] VAL_HIGH = NUM_W'((SPAN + TOL) * (1 << Q_BITS));
   localparam logic signed [NUM_W-1:0] VAL_LOW  = NUM_W'(-TOL * (1 << Q_BITS));
   localparam logic signed [NUM_W-1:0] BRK_BIAS = NUM_W'(1 << Q_BITS);
   localparam logic signed [NUM_W-1:0] ACC_BIAS = NUM_W'(21 * (1 << Q_BITS));

   localparam logic [DEN_W-1:0] DEN_BRK_LIN = 26'd22;
   localparam logic [DEN_W-1:0] DEN_ACC_LIN = 26'd37;
   localparam logic [DEN_W-1:0] DEN_BRK_SCL = 26'd185;

   function automatic logic [24:0] coef_a(input logic [1:0] sel);
      logic [24:0] r;
      unique case (sel)
         SEL_ACC1: r = 25'd310249;
         SEL_ACC2: r = 25'd21846276;
         default:  r = 25'd473344;
      endcase
      return r;
   endfunction

   function automatic logic [25:0] coef_b(input logic [1:0] sel);
      logic [25:0] r;
      unique case (sel)
         SEL_ACC1: r = 26'd665118;
         SEL_ACC2: r = 26'd46552352;
         default:  r = 26'd673148;
      endcase
      return r;
   endfunction

   function automatic logic [24:0] coef_c(input logic [1:0] sel);
      logic [24:0] r;
      unique case (sel)
         SEL_ACC1: r = 25'd407769;
         SEL_ACC2: r = 25'd28606701;
         default:  r = 25'd435029;
      endcase
      return r;
   endfunction

   function automatic logic [12:0] coef_pa(input logic [1:0] sel);
      logic [12:0] r;
      unique case (sel)
         SEL_ACC1: r = 13'd557;
         SEL_ACC2: r = 13'd4674;
         default:  r = 13'd688;
      endcase
      return r;
   endfunction

   function automatic logic [11:0] coef_pb(input logic [1:0] sel);
      logic [11:0] r;
      unique case (sel)
         SEL_ACC1: r = 12'd327;
         SEL_ACC2: r = 12'd2699;
         default:  r = 12'd203;
      endcase
      return r;
   endfunction

   function automatic logic [13:0] coef_k(input logic [1:0] sel);
      logic [13:0] r;
      unique case (sel)
         SEL_ACC1: r = 14'd9120;
         SEL_ACC2: r = 14'd5200;
         default:  r = 14'd406;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/psl_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on psl_pkg for field widths.
`default_nettype none
interface psl_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [1:0]                  sensor_sel;
   logic [psl_pkg::ADC_W-1:0]   adc_reading;

   modport source (output valid, req_type, sensor_sel, adc_reading, input ready);
   modport sink   (input valid, req_type, sensor_sel, adc_reading, output ready);
endinterface

interface psl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [psl_pkg::CODE_W-1:0]  pedal_code;

   modport source (output valid, pedal_code, input ready);
   modport sink   (input valid, pedal_code, output ready);
endinterface
`default_nettype wire

### sv/psl_sqrt.sv
// Bit-serial restoring square root, one root bit per cycle, Q16 result.
// Depends on psl_pkg.
`default_nettype none
module psl_sqrt #(
   parameter int RAD_W = psl_pkg::RAD_W
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic [RAD_W-1:0]                         radicand,
   output logic                                          busy,
   output logic [(RAD_W + 2*psl_pkg::Q_BITS)/2-1:0]      root
);
   import psl_pkg::*;

   localparam int OP_W  = RAD_W + 2 * Q_BITS;
   localparam int RT_W  = OP_W / 2;
   localparam int REM_W = RT_W + 4;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic              busy_ff, busy_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [RT_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_sh, trial;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], op_ff[OP_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      busy_in = busy_ff;
      op_in   = op_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         op_in   = {radicand, {(2*Q_BITS){1'b0}}};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RT_W);
      end else if (busy_ff) begin
         op_in  = op_ff << 2;
         cnt_in = cnt_ff - 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RT_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

### sv/psl_div.sv
// Bit-serial restoring divider, signed dividend, positive divisor,
// quotient truncated toward zero. Depends on psl_pkg.
`default_nettype none
module psl_div #(
   parameter int NUM_W = psl_pkg::NUM_W,
   parameter int DEN_W = psl_pkg::DEN_W
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [NUM_W-1:0]  dividend,
   input  wire logic [DEN_W-1:0]         divisor,
   output logic                          busy,
   output logic signed [NUM_W-1:0]       quotient
);
   import psl_pkg::*;

   localparam int MAG_W = NUM_W - 1;
   localparam int CNT_W = $clog2(MAG_W + 1);

   logic              busy_ff, busy_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  dq_ff, dq_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DEN_W:0]    rem_sh;
   logic signed [NUM_W-1:0] mag_full;

   always_comb begin
      rem_sh   = {rem_ff, dq_ff[MAG_W-1]};
      mag_full = dividend[NUM_W-1] ? -dividend : dividend;
      busy_in  = busy_ff;
      neg_in   = neg_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[NUM_W-1];
         dq_in   = mag_full[MAG_W-1:0];
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(MAG_W);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rem_sh - {1'b0, den_ff});
            dq_in  = {dq_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            dq_in  = {dq_ff[MAG_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -signed'({1'b0, dq_ff}) : signed'({1'b0, dq_ff});
endmodule
`default_nettype wire

### sv/pedal_sensor_linearizer.sv
// Accelerator requests and brake calibrations run one serial square root and two serial
//   divisions, a brake convert a third division; an invalid-sensor convert returns code 0.
// Throughput: one item at a time; a new beat is taken once the previous result is in
//   the output register or a calibration is done. Reset: synchronous, offsets back to 2,
//   output empty.
`default_nettype none
module pedal_sensor_linearizer (
   input wire logic   clock,
   input wire logic   reset,
   psl_req_if.sink    req,
   psl_rsp_if.source  rsp
);
   import psl_pkg::*;

   typedef enum logic [20:0] {
      ST_IDLE  = 21'h000001, ST_MUL1 = 21'h000002, ST_MUL2 = 21'h000004,
      ST_SUM   = 21'h000008, ST_RAD  = 21'h000010, ST_SQGO = 21'h000020,
      ST_SQW   = 21'h000040, ST_NUM  = 21'h000080, ST_SCL  = 21'h000100,
      ST_DGO1  = 21'h000200, ST_DW1  = 21'h000400, ST_LIN  = 21'h000800,
      ST_LIN2  = 21'h001000, ST_DGO2 = 21'h002000, ST_DW2  = 21'h004000,
      ST_APPLY = 21'h008000, ST_BRK  = 21'h010000, ST_DGO3 = 21'h020000,
      ST_DW3   = 21'h040000, ST_CODE = 21'h080000, ST_EMIT = 21'h100000
   } state_type;

   state_type               state_ff, state_in;
   logic                    type_ff, type_in;
   logic [1:0]              sel_ff, sel_in;
   logic [ADC_W-1:0]        x_ff, x_in;
   logic [2*ADC_W-1:0]      x2_ff, x2_in;
   logic [37:0]             m1_ff, m1_in;
   logic [48:0]             m2_ff, m2_in;
   logic [P_W-1:0]          p_ff, p_in;
   logic [DEN_W-1:0]        d_ff, d_in;
   logic [RAD_W-1:0]        rad_ff, rad_in;
   logic signed [NUM_W-1:0] acc_ff, acc_in;
   logic [OFF_W-1:0]        brk_off_ff, brk_off_in;
   logic [OFF_W-1:0]        a1_off_ff, a1_off_in;
   logic [OFF_W-1:0]        a2_off_ff, a2_off_in;
   logic [CODE_W-1:0]       code_ff, code_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]       rsp_code_ff, rsp_code_in;

   logic                    sq_start, sq_busy;
   logic [ROOT_W-1:0]       sq_root;
   logic                    dv_start, dv_busy;
   logic [DEN_W-1:0]        dv_den;
   logic signed [NUM_W-1:0] dv_quot;
   logic [OFF_W-1:0]        cur_off, trunc8;
   logic signed [NUM_W-1:0] lin_neg, off_q;
   logic [ADC_W:0]          span_x;
   logic                    out_free;

   psl_sqrt #(.RAD_W(RAD_W)) u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(rad_ff),
      .busy(sq_busy), .root(sq_root)
   );

   psl_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(acc_ff),
      .divisor(dv_den), .busy(dv_busy), .quotient(dv_quot)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      unique case (sel_ff)
         SEL_ACC1: cur_off = a1_off_ff;
         SEL_ACC2: cur_off = a2_off_ff;
         default:  cur_off = brk_off_ff;
      endcase
      off_q   = signed'({{(NUM_W-OFF_W-Q_BITS){cur_off[OFF_W-1]}}, cur_off, {Q_BITS{1'b0}}});
      lin_neg = -acc_ff;
      // integer part truncated toward zero
      trunc8  = acc_ff[NUM_W-1] ? OFF_W'(-lin_neg[Q_BITS+OFF_W-1:Q_BITS])
                                : acc_ff[Q_BITS+OFF_W-1:Q_BITS];
      span_x  = (ADC_W+1)'(ADC_FULL) - (ADC_W+1)'(x_ff);
   end

   always_comb begin
      state_in   = state_ff;
      type_in    = type_ff;
      sel_in     = sel_ff;
      x_in       = x_ff;
      x2_in      = x2_ff;
      m1_in      = m1_ff;
      m2_in      = m2_ff;
      p_in       = p_ff;
      d_in       = d_ff;
      rad_in     = rad_ff;
      acc_in     = acc_ff;
      brk_off_in = brk_off_ff;
      a1_off_in  = a1_off_ff;
      a2_off_in  = a2_off_ff;
      code_in    = code_ff;
      sq_start   = 1'b0;
      dv_start   = 1'b0;
      dv_den     = d_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               type_in = req.req_type;
               sel_in  = req.sensor_sel;
               x_in    = req.adc_reading;
               if (req.sensor_sel == SEL_NONE) begin
                  if (req.req_type == REQ_CONVERT) begin
                     code_in  = CODE_LOW;
                     state_in = ST_EMIT;
                  end
               end else begin
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            x2_in    = (2*ADC_W)'(x_ff) * (2*ADC_W)'(x_ff);
            m1_in    = 38'(coef_b(sel_ff)) * 38'(x_ff);
            p_in     = P_W'({coef_pa(sel_ff), {ADC_W{1'b0}}})
                       - P_W'(24'(coef_pb(sel_ff)) * 24'(x_ff));
            d_in     = DEN_W'(27'(coef_k(sel_ff)) * 27'(span_x));
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            m2_in    = 49'(coef_c(sel_ff)) * 49'(x2_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rad_in   = RAD_W'({coef_a(sel_ff), {(2*ADC_W){1'b0}}}) + RAD_W'(m2_ff);
            state_in = ST_RAD;
         end
         ST_RAD: begin
            rad_in   = rad_ff - RAD_W'({m1_ff, {ADC_W{1'b0}}});
            state_in = ST_SQGO;
         end
         ST_SQGO: begin
            sq_start = 1'b1;
            state_in = ST_SQW;
         end
         ST_SQW: begin
            if (!sq_busy) begin
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            acc_in   = signed'(NUM_W'({p_ff, {Q_BITS{1'b0}}}))
                       - signed'(NUM_W'(sq_root));
            state_in = ST_SCL;
         end
         ST_SCL: begin
            if (sel_ff == SEL_ACC1) begin
               acc_in = acc_ff + (acc_ff <<< 4);
            end
            state_in = ST_DGO1;
         end
         ST_DGO1: begin
            dv_start = 1'b1;
            state_in = ST_DW1;
         end
         ST_DW1: begin
            if (!dv_busy) begin
               acc_in   = dv_quot;
               state_in = ST_LIN;
            end
         end
         ST_LIN: begin
            if (sel_ff == SEL_BRAKE) begin
               acc_in = (acc_ff <<< 5) + (acc_ff <<< 4) + (acc_ff <<< 1) - BRK_BIAS;
            end else begin
               acc_in = (acc_ff <<< 6) + (acc_ff <<< 5) + (acc_ff <<< 2) - ACC_BIAS;
            end
            state_in = ST_LIN2;
         end
         ST_LIN2: begin
            acc_in   = (acc_ff <<< 7) - acc_ff;
            state_in = ST_DGO2;
         end
         ST_DGO2: begin
            dv_den   = (sel_ff == SEL_BRAKE) ? DEN_BRK_LIN : DEN_ACC_LIN;
            dv_start = 1'b1;
            state_in = ST_DW2;
         end
         ST_DW2: begin
            if (!dv_busy) begin
               acc_in   = dv_quot;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (type_ff == REQ_CALIB) begin
               unique case (sel_ff)
                  SEL_ACC1: a1_off_in  = a1_off_ff + trunc8;
                  SEL_ACC2: a2_off_in  = a2_off_ff + trunc8;
                  default:  brk_off_in = brk_off_ff + trunc8;
               endcase
               state_in = ST_IDLE;
            end else begin
               acc_in   = acc_ff - off_q;
               state_in = (sel_ff == SEL_BRAKE) ? ST_BRK : ST_CODE;
            end
         end
         ST_BRK: begin
            acc_in   = (acc_ff <<< 8) - (acc_ff <<< 1);
            state_in = ST_DGO3;
         end
         ST_DGO3: begin
            dv_den   = DEN_BRK_SCL;
            dv_start = 1'b1;
            state_in = ST_DW3;
         end
         ST_DW3: begin
            if (!dv_busy) begin
               acc_in   = dv_quot;
               state_in = ST_CODE;
            end
         end
         ST_CODE: begin
            priority if (!acc_ff[NUM_W-1] && acc_ff < VAL_SPAN) begin
               code_in = acc_ff[Q_BITS+CODE_W-1:Q_BITS] + 1'b1;
            end else if (acc_ff[NUM_W-1]) begin
               code_in = (acc_ff < VAL_LOW) ? CODE_LOW : CODE_MIN;
            end else begin
               code_in = (acc_ff >= VAL_HIGH) ? CODE_HIGH : CODE_MAX;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register decouples the result beat from the request side
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      if (state_ff == ST_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = code_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         brk_off_ff   <= OFF_RESET;
         a1_off_ff    <= OFF_RESET;
         a2_off_ff    <= OFF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         brk_off_ff   <= brk_off_in;
         a1_off_ff    <= a1_off_in;
         a2_off_ff    <= a2_off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff     <= type_in;
      sel_ff      <= sel_in;
      x_ff        <= x_in;
      x2_ff       <= x2_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      p_ff        <= p_in;
      d_ff        <= d_in;
      rad_ff      <= rad_in;
      acc_ff      <= acc_in;
      code_ff     <= code_in;
      rsp_code_ff <= rsp_code_in;
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pedal_code = rsp_code_ff;
endmodule
`default_nettype wire

### dv/tb_pedal_sensor_linearizer.sv
// Testbench for pedal_sensor_linearizer: random and directed requests, scoreboarded codes.
// Depends on psl_pkg, psl_if and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_pedal_sensor_linearizer;
   import psl_pkg::*;

   typedef struct packed {
      logic        req_type;
      logic [1:0]  sensor_sel;
      logic [11:0] adc_reading;
   } pedal_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   psl_req_if req();
   psl_rsp_if rsp();

   pedal_sensor_linearizer uut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   pedal_req_type pending_reqs[$];
   logic [7:0]   expected_codes[$];
   logic [7:0]   off_brake, off_acc1, off_acc2;
   int           send_idle_pct, recv_idle_pct;
   bit           hold_send;
   int           errors, n_sent, n_codes, n_calib, quiet_cycles;
   bit           stim_done;

   // floor(sqrt(r * 2^32)) by the bitwise method
   function automatic longint unsigned root_q16(input longint unsigned r);
      logic [127:0] rad, rem, trial, root;
      rad = {r, 32'd0};
      rem = 0; root = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
         trial = (root << 2) | 128'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 128'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic longint pedal_lin(input logic [1:0] sel, input logic [11:0] rd);
      longint x, a, p, r, c, k, v;
      x = rd; a = ADC_FULL;
      if (sel == SEL_ACC1) begin
         c = 17; k = 9120; p = 557 * a - 327 * x;
         r = 310249 * a * a - 665118 * a * x + 407769 * x * x;
      end else if (sel == SEL_ACC2) begin
         c = 1; k = 5200; p = 4674 * a - 2699 * x;
         r = 21846276 * a * a - 46552352 * a * x + 28606701 * x * x;
      end else begin
         c = 1; k = 406; p = 688 * a - 203 * x;
         r = 473344 * a * a - 673148 * a * x + 435029 * x * x;
      end
      v = c * (p * 65536 - longint'(root_q16(r))) / (k * (a - x));
      if (sel == SEL_BRAKE) return (50 * v - 65536) * 127 / 22;
      return (100 * v - 21 * 64'sd65536) * 127 / 37;
   endfunction

   // updates offsets; pushes a code when the request yields one
   task automatic predict_pedal(input pedal_req_type it);
      longint lin, val;
      logic [7:0] off, code;
      if (it.sensor_sel == SEL_NONE) begin
         if (it.req_type == REQ_CONVERT) expected_codes.push_back(CODE_LOW);
         return;
      end
      off = (it.sensor_sel == SEL_ACC1) ? off_acc1 :
            (it.sensor_sel == SEL_ACC2) ? off_acc2 : off_brake;
      lin = pedal_lin(it.sensor_sel, it.adc_reading);
      if (it.req_type == REQ_CALIB) begin
         off = off + 8'(lin / 65536);
         case (it.sensor_sel)
            SEL_ACC1: off_acc1 = off;
            SEL_ACC2: off_acc2 = off;
            default:  off_brake = off;
         endcase
         return;
      end
      val = lin - longint'($signed(off)) * 65536;
      if (it.sensor_sel == SEL_BRAKE) val = val * 254 / 185;
      if (val >= 0 && val < 254 * 64'sd65536) code = 8'(val / 65536 + 1);
      else if (val < 0) code = (val < -10 * 64'sd65536) ? CODE_LOW : CODE_MIN;
      else code = (val >= 264 * 64'sd65536) ? CODE_HIGH : CODE_MAX;
      expected_codes.push_back(code);
   endtask

   // driver: changes on falling edge; prediction at the accepting rising edge
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && !req.ready) begin
         // hold beat
      end else if (!hold_send && pending_reqs.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
         pedal_req_type it;
         it = pending_reqs.pop_front();
         req.valid <= 1'b1;
         {req.req_type, req.sensor_sel, req.adc_reading} <= it;
      end else begin
         req.valid <= 1'b0;
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            predict_pedal({req.req_type, req.sensor_sel, req.adc_reading});
            n_sent++;
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_codes.size() == 0) begin
               $display("%0t: unexpected beat, actual %0d", $time, rsp.pedal_code);
               errors++;
            end else begin
               logic [7:0] e;
               e = expected_codes.pop_front();
               if (e !== rsp.pedal_code) begin
                  $display("%0t: pedal_code mismatch, expected %0d actual %0d",
                           $time, e, rsp.pedal_code);
                  errors++;
               end
               n_codes++;
            end
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles > 20000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic pedal_req_type rand_req();
      pedal_req_type it;
      int m;
      it.req_type = ($urandom_range(99) < 8) ? REQ_CALIB : REQ_CONVERT;
      it.sensor_sel = ($urandom_range(99) < 6) ? SEL_NONE : 2'($urandom_range(2));
      m = $urandom_range(9);
      if (m == 0) it.adc_reading = 12'($urandom_range(15));
      else if (m == 1) it.adc_reading = 12'(4095 - $urandom_range(15));
      else it.adc_reading = 12'($urandom);
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req.valid || expected_codes.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      req.valid = 1'b0; req.req_type = 1'b0; req.sensor_sel = 2'd0; req.adc_reading = 12'd0;
      rsp.ready = 1'b0;
      off_brake = OFF_RESET; off_acc1 = OFF_RESET; off_acc2 = OFF_RESET;
      send_idle_pct = 16; recv_idle_pct = 74; hold_send = 0;
      errors = 0; n_sent = 0; n_codes = 0; quiet_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed: field extremes per sensor, invalid sensor, calibration both ways
      for (int s = 0; s < 4; s++) begin
         pending_reqs.push_back({REQ_CONVERT, 2'(s), 12'd0});
         pending_reqs.push_back({REQ_CONVERT, 2'(s), 12'd4095});
         pending_reqs.push_back({REQ_CONVERT, 2'(s), 12'd2048});
      end
      pending_reqs.push_back({REQ_CALIB, SEL_NONE, 12'd1234});
      for (int s = 0; s < 3; s++) begin
         pending_reqs.push_back({REQ_CALIB, 2'(s), 12'd0});
         pending_reqs.push_back({REQ_CONVERT, 2'(s), 12'd0});
         pending_reqs.push_back({REQ_CALIB, 2'(s), 12'd4095});
         pending_reqs.push_back({REQ_CONVERT, 2'(s), 12'd1000});
      end
      for (int ph = 0; ph < 3; ph++) begin
         for (int i = 0; i < 350; i++) pending_reqs.push_back(rand_req());
         while (pending_reqs.size() > 175) @(posedge clock);
         if (ph == 0) begin
            // let the pipeline drain completely before sending more
            hold_send = 1;
            while (req.valid || expected_codes.size() > 0) @(posedge clock);
            repeat (250) @(posedge clock);
            hold_send = 0;
         end
         wait_drained();
         if (ph == 0) begin send_idle_pct = 74; recv_idle_pct = 16; end
         else begin send_idle_pct = 0; recv_idle_pct = 0; end
      end
      $display("Sent %0d requests (%0d calibrations included), checked %0d codes.",
               n_sent, n_calib, n_codes);
      if (errors == 0 && expected_codes.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock)
      if (!reset && req.valid && req.ready && req.req_type == REQ_CALIB) n_calib++;
   initial n_calib = 0;
endmodule
`default_nettype wire
